// ===== rtl/rlphe_pkg.sv =====
// Shared types and constants for the RLP header encoder.
// No dependencies; used by every rtl file of the block.
package rlphe_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0]  LIST_SHORT_BASE = 8'hc0;
    localparam logic [7:0]  LIST_LONG_BASE  = 8'hf7;
    localparam logic [7:0]  STR_SHORT_BASE  = 8'h80;
    localparam logic [7:0]  STR_LONG_BASE   = 8'hb7;
    localparam logic [31:0] SHORT_LIMIT     = 32'd55;

    // Command codes of the input item.
    localparam logic CMD_LIST   = 1'b0;
    localparam logic CMD_STRING = 1'b1;

    // Byte-emission job passed from the classifier to the emitter.
    typedef struct packed {
        logic [7:0]  prefix;    // first byte emitted, or the only byte
        logic [2:0]  len_count; // number of big-endian length bytes (0..4)
        logic [31:0] len;
        logic        has_data;  // trailing payload byte follows
        logic [7:0]  data;
    } desc_t;

    // Queue status seen by the top level.
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    // Emitter status seen by the top level.
    typedef struct packed {
        logic busy;
        logic pop;
    } back_status_t;

endpackage

// ===== rtl/rlphe_front.sv =====
// Front end: classifies one input item into a byte-emission job.
// Depends on rlphe_pkg.
module rlphe_front (
    input  logic               command,
    input  logic               first,
    input  logic [7:0]         data_byte,
    input  logic [31:0]        payload_len,
    output rlphe_pkg::desc_t   desc
);

    logic       len_short;
    logic [2:0] n_len;
    logic [7:0] base_short;
    logic [7:0] base_long;

    assign len_short = (payload_len <= rlphe_pkg::SHORT_LIMIT);

    // Count of significant length bytes, at least one.
    always_comb begin
        if (payload_len[31:24] != 8'd0) begin
            n_len = 3'd4;
        end else if (payload_len[23:16] != 8'd0) begin
            n_len = 3'd3;
        end else if (payload_len[15:8] != 8'd0) begin
            n_len = 3'd2;
        end else begin
            n_len = 3'd1;
        end
    end

    assign base_short = (command == rlphe_pkg::CMD_LIST) ?
                        rlphe_pkg::LIST_SHORT_BASE : rlphe_pkg::STR_SHORT_BASE;
    assign base_long  = (command == rlphe_pkg::CMD_LIST) ?
                        rlphe_pkg::LIST_LONG_BASE : rlphe_pkg::STR_LONG_BASE;

    always_comb begin
        desc           = '0;
        desc.len       = payload_len;
        desc.data      = data_byte;
        if (command == rlphe_pkg::CMD_STRING && !first) begin
            desc.prefix = data_byte;
        end else if (command == rlphe_pkg::CMD_STRING && payload_len == 32'd1
                     && data_byte == 8'd0) begin
            desc.prefix = rlphe_pkg::STR_SHORT_BASE;
        end else if (command == rlphe_pkg::CMD_STRING && payload_len == 32'd1
                     && !data_byte[7]) begin
            desc.prefix = data_byte;
        end else if (command == rlphe_pkg::CMD_STRING && payload_len == 32'd0) begin
            desc.prefix = rlphe_pkg::STR_SHORT_BASE;
        end else begin
            // header, then the byte itself for strings
            desc.has_data = (command == rlphe_pkg::CMD_STRING);
            if (len_short) begin
                desc.prefix = base_short + payload_len[7:0];
            end else begin
                desc.prefix    = base_long + {5'd0, n_len};
                desc.len_count = n_len;
            end
        end
    end

endmodule

// ===== rtl/rlphe_fifo.sv =====
// Short job queue between classifier and emitter.
// Depends on rlphe_pkg.
module rlphe_fifo #(
    parameter int unsigned DEPTH = rlphe_pkg::QUEUE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  rlphe_pkg::desc_t        push_desc,
    input  logic                    pop,
    output rlphe_pkg::desc_t        head,
    output rlphe_pkg::q_status_t    status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    rlphe_pkg::desc_t  mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.valid = (count_reg != '0);
    assign head         = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/rlphe_back.sv =====
// Back end: steps through a job one byte per cycle into the output register, unless m_ready stalls it.
// Depends on rlphe_pkg.
module rlphe_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  rlphe_pkg::desc_t           q_head,
    output logic                       q_pop,
    output rlphe_pkg::back_status_t    status,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_last_of_run
);

    rlphe_pkg::desc_t cur_reg, cur_next;
    rlphe_pkg::desc_t cur;
    logic       busy_reg, busy_next;
    logic [2:0] step_reg, step_next;
    logic [2:0] step;
    logic [2:0] total;
    logic [2:0] len_idx;
    logic [7:0] byte_sel;
    logic       last_sel;
    logic       have_cur;
    logic       advance;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] out_byte_reg;
    logic       last_reg;

    assign have_cur = busy_reg || q_valid;
    assign cur      = busy_reg ? cur_reg : q_head;
    assign step     = busy_reg ? step_reg : 3'd0;
    assign total    = 3'd1 + cur.len_count + {2'd0, cur.has_data};
    assign len_idx  = cur.len_count - step + 3'd1;
    assign last_sel = (step == total - 3'd1);
    assign advance  = have_cur && (!m_valid_reg || m_ready);
    assign q_pop    = advance && !busy_reg;

    // Prefix first, then length bytes most significant first, then the data byte.
    always_comb begin
        if (step == 3'd0) begin
            byte_sel = cur.prefix;
        end else if (step <= cur.len_count) begin
            case (len_idx)
                3'd1:    byte_sel = cur.len[7:0];
                3'd2:    byte_sel = cur.len[15:8];
                3'd3:    byte_sel = cur.len[23:16];
                3'd4:    byte_sel = cur.len[31:24];
                default: byte_sel = cur.data;
            endcase
        end else begin
            byte_sel = cur.data;
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (advance) begin
            m_valid_next = 1'b1;
            cur_next     = cur;
            busy_next    = !last_sel;
            step_next    = step + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_byte_reg <= byte_sel;
            last_reg     <= last_sel;
        end
        cur_reg  <= cur_next;
        step_reg <= step_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign status.busy   = busy_reg;
    assign status.pop    = q_pop;
    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_last_of_run = last_reg;

endmodule

// ===== rtl/rlp_header_encoder.sv =====
// RLP header encoder: an accepted item is written into the queue, then its first byte
// into the output register. One item per cycle when each item yields one byte and
// m_ready is high; an item with a header holds the back-end sequencer for its prefix,
// length bytes and data byte, one byte per cycle unless stalled, while the queue takes items.
// Reset (aresetn, synchronous) empties the queue and the output register; no clearing pass.
module rlp_header_encoder #(
    parameter int unsigned QUEUE_DEPTH = rlphe_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic        s_first,
    input  logic [7:0]  s_data_byte,
    input  logic [31:0] s_payload_len,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run
);

    rlphe_pkg::desc_t          front_desc;
    rlphe_pkg::desc_t          q_head;
    rlphe_pkg::q_status_t      q_status;
    rlphe_pkg::back_status_t   back_status;
    logic                      q_push;
    logic                      q_pop;

    assign s_ready = !q_status.full;
    assign q_push  = s_valid && s_ready;

    rlphe_front u_front (
        .command     (s_command),
        .first       (s_first),
        .data_byte   (s_data_byte),
        .payload_len (s_payload_len),
        .desc        (front_desc)
    );

    rlphe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (front_desc),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    rlphe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_status.valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .status        (back_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run)
    );

    // The emitter takes a job only from a non-empty queue and only when idle.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.pop |-> (q_status.valid && !back_status.busy))
        else $error("job taken from empty queue or while busy");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("item written into full queue");

    // A job that is not finished keeps the output register filled.
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("gap inside a run of output bytes");

    a_busy_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |-> back_status.busy)
        else $error("emitter idle with a run unfinished");

endmodule
